// ----- rtl/utce_pkg.sv -----
// ---------------------------------------------------------------------------
// utce_pkg: shared types and constants for the UTCTime to epoch converter
// Holds the field bundle passed from the character parser to the
// conversion sequencer, the sequencer states and the month table.
// ---------------------------------------------------------------------------
package utce_pkg;

    localparam int CHAR_W  = 8;
    localparam int DIG_W   = 7;
    localparam int POS_W   = 4;
    localparam int EPOCH_W = 33;
    localparam int ACC_W   = 34;
    localparam int MUL_B_W = 10;
    localparam int YOFF_W  = 8;
    localparam int MSTART_W = 9;

    localparam logic [POS_W-1:0] POS_MIN_LEN = 4'd9;
    localparam logic [POS_W-1:0] POS_SEC_HI  = 4'd10;
    localparam logic [POS_W-1:0] POS_SEC_LO  = 4'd11;
    localparam logic [POS_W-1:0] POS_MAX     = 4'd15;

    localparam logic [DIG_W-1:0] YEAR_PIVOT = 7'd50;
    localparam logic [DIG_W-1:0] MONTH_MAX  = 7'd12;

    localparam logic [1:0] SEC_NONE = 2'd0;
    localparam logic [1:0] SEC_ONE  = 2'd1;
    localparam logic [1:0] SEC_BOTH = 2'd2;

    localparam logic signed [MUL_B_W-1:0] DAYS_PER_YEAR = 10'sd365;
    localparam logic signed [MUL_B_W-1:0] HOURS_PER_DAY = 10'sd24;
    localparam logic signed [MUL_B_W-1:0] SIXTY         = 10'sd60;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DAYS,
        ST_HOURS,
        ST_MINS,
        ST_SECS
    } t_state;

    typedef struct packed {
        logic                     ok;
        logic signed [YOFF_W-1:0] y_off;     // year - 1970
        logic                     leap;
        logic [3:0]               month_idx; // month - 1
        logic [DIG_W-1:0]         day;
        logic [DIG_W-1:0]         hour;
        logic [DIG_W-1:0]         minute;
        logic [DIG_W-1:0]         second;
    } t_fields;

    function automatic logic [MSTART_W-1:0] month_start(input logic [3:0] idx);
        logic [MSTART_W-1:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/utctime_to_epoch_seconds_top.sv -----
// ---------------------------------------------------------------------------
// utctime_to_epoch_seconds_top: UTCTime string to seconds since 1970
// Parses "YYMMDDhhmm[ss]..." one character per word and emits one result
// word on the character marked by tlast.
// ---------------------------------------------------------------------------
// Characters are taken one per cycle while s_axis_tready is high. The word
// with tlast is accepted and then makes four passes through the shared
// multiply-add unit (days, hours, minutes, seconds), during which
// s_axis_tready is low; the last pass also waits while an earlier result is
// still held in the output register. Strings that are shorter than 10
// characters, carry a non-digit in the first 10, or have a month outside
// 1..12 give a result with tuser low and zero data.
module utctime_to_epoch_seconds_top
    import utce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [32:0] epoch_seconds, [39:33] zero
    output logic [0:0]  m_axis_tuser    // [0] valid_res
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [DIG_W-1:0] r_year, n_year;
    logic [DIG_W-1:0] r_month, n_month;
    logic [DIG_W-1:0] r_day, n_day;
    logic [DIG_W-1:0] r_hour, n_hour;
    logic [DIG_W-1:0] r_min, n_min;
    logic [DIG_W-1:0] r_sec, n_sec;
    logic [1:0]       r_sok, n_sok;
    logic             r_bad, n_bad;

    logic               accept;
    logic               start;
    logic               busy;
    logic               is_digit;
    logic [3:0]         dv;
    logic [DIG_W-1:0]   dv_tens;
    t_fields            fields;
    logic               res_ok;
    logic [EPOCH_W-1:0] res_sec;

    assign s_axis_tready = !busy;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign start  = accept && s_axis_tlast;

    assign is_digit = (s_axis_tdata >= 8'h30) && (s_axis_tdata <= 8'h39);
    assign dv       = is_digit ? s_axis_tdata[3:0] : 4'd0;
    assign dv_tens  = DIG_W'({3'd0, dv} * 7'd10);

    always_comb begin
        n_pos   = r_pos;
        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        n_hour  = r_hour;
        n_min   = r_min;
        n_sec   = r_sec;
        n_sok   = r_sok;
        n_bad   = r_bad;
        if (r_pos < POS_SEC_HI) begin
            if (!is_digit) n_bad = 1'b1;
            unique case (r_pos[3:1])
                3'd0:    n_year  = r_pos[0] ? DIG_W'(r_year + 7'(dv))  : dv_tens;
                3'd1:    n_month = r_pos[0] ? DIG_W'(r_month + 7'(dv)) : dv_tens;
                3'd2:    n_day   = r_pos[0] ? DIG_W'(r_day + 7'(dv))   : dv_tens;
                3'd3:    n_hour  = r_pos[0] ? DIG_W'(r_hour + 7'(dv))  : dv_tens;
                default: n_min   = r_pos[0] ? DIG_W'(r_min + 7'(dv))   : dv_tens;
            endcase
        end else if (r_pos == POS_SEC_HI) begin
            if (is_digit) begin
                n_sok = SEC_ONE;
                n_sec = dv_tens;
            end
        end else if (r_pos == POS_SEC_LO) begin
            if (is_digit && r_sok == SEC_ONE) begin
                n_sok = SEC_BOTH;
                n_sec = DIG_W'(r_sec + 7'(dv));
            end
        end
        if (r_pos < POS_MAX) n_pos = r_pos + 4'd1;
    end

    // bundle the finished fields for the sequencer
    always_comb begin
        fields.ok = (r_pos >= POS_MIN_LEN) && !n_bad &&
                    (n_month >= 7'd1) && (n_month <= MONTH_MAX);
        fields.y_off = (n_year < YEAR_PIVOT) ? YOFF_W'({1'b0, n_year} + 8'd30)
                                             : YOFF_W'({1'b0, n_year} - 8'd70);
        fields.leap      = (n_year[1:0] == 2'd0);
        fields.month_idx = n_month[3:0] - 4'd1;
        fields.day       = n_day;
        fields.hour      = n_hour;
        fields.minute    = n_min;
        fields.second    = (n_sok == SEC_BOTH) ? n_sec : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || start) begin
            r_pos   <= '0;
            r_year  <= '0;
            r_month <= '0;
            r_day   <= '0;
            r_hour  <= '0;
            r_min   <= '0;
            r_sec   <= '0;
            r_sok   <= SEC_NONE;
            r_bad   <= 1'b0;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_year  <= n_year;
            r_month <= n_month;
            r_day   <= n_day;
            r_hour  <= n_hour;
            r_min   <= n_min;
            r_sec   <= n_sec;
            r_sok   <= n_sok;
            r_bad   <= n_bad;
        end
    end

    utce_conv u_conv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_fields  (fields),
        .o_busy    (busy),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_ok      (res_ok),
        .o_seconds (res_sec)
    );

    assign m_axis_tdata = {7'd0, res_sec};
    assign m_axis_tuser = res_ok;

endmodule

// ----- rtl/utce_conv.sv -----
// ---------------------------------------------------------------------------
// utce_conv: epoch seconds sequencer
// One multiply-add unit evaluates the total in Horner form over four
// steps: days, then *24 + hour, *60 + minute, *60 + second. The result
// lands in an output register that holds until taken.
// ---------------------------------------------------------------------------
module utce_conv
    import utce_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_fields            i_fields,
    output logic               o_busy,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_ok,
    output logic [EPOCH_W-1:0] o_seconds
);

    t_state r_state, n_state;
    t_fields r_fld;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_out_valid;
    logic                    r_out_ok;
    logic [EPOCH_W-1:0]      r_out_sec;

    logic signed [ACC_W-1:0]         mul_a;
    logic signed [MUL_B_W-1:0]       mul_b;
    logic signed [ACC_W-1:0]         addend;
    logic signed [ACC_W+MUL_B_W-1:0] prod;
    logic signed [ACC_W-1:0]         mac;
    logic signed [YOFF_W-1:0]        yp1;
    logic signed [ACC_W-1:0]         day_terms;
    logic                            out_free;
    logic                            acc_en;
    logic                            out_load;

    assign out_free = !r_out_valid || i_ready;

    // floor((year - 1969) / 4) gives the leap days since 1970 in this range
    always_comb begin
        yp1 = r_fld.y_off + 8'sd1;
        day_terms = ACC_W'(yp1 >>> 2)
                  + $signed({{(ACC_W-MSTART_W){1'b0}}, month_start(r_fld.month_idx)})
                  + $signed({{(ACC_W-1){1'b0}}, (r_fld.leap && r_fld.month_idx >= 4'd2)})
                  + $signed({{(ACC_W-DIG_W){1'b0}}, r_fld.day})
                  - 34'sd1;
    end

    always_comb begin
        mul_a  = r_acc;
        mul_b  = SIXTY;
        addend = '0;
        unique case (r_state)
            ST_DAYS: begin
                mul_a  = ACC_W'(r_fld.y_off);
                mul_b  = DAYS_PER_YEAR;
                addend = day_terms;
            end
            ST_HOURS: begin
                mul_b  = HOURS_PER_DAY;
                addend = $signed({{(ACC_W-DIG_W){1'b0}}, r_fld.hour});
            end
            ST_MINS: begin
                addend = $signed({{(ACC_W-DIG_W){1'b0}}, r_fld.minute});
            end
            ST_SECS: begin
                addend = $signed({{(ACC_W-DIG_W){1'b0}}, r_fld.second});
            end
            default: begin
                addend = '0;
            end
        endcase
        prod = mul_a * mul_b;
        mac  = prod[ACC_W-1:0] + addend;
    end

    always_comb begin
        n_state  = r_state;
        acc_en   = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_DAYS;
            end
            ST_DAYS: begin
                acc_en  = 1'b1;
                n_state = ST_HOURS;
            end
            ST_HOURS: begin
                acc_en  = 1'b1;
                n_state = ST_MINS;
            end
            ST_MINS: begin
                acc_en  = 1'b1;
                n_state = ST_SECS;
            end
            ST_SECS: begin
                // hold the last step until the output register is free
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) r_fld <= i_fields;
        if (acc_en) r_acc <= mac;
        if (out_load) begin
            r_out_ok  <= r_fld.ok;
            r_out_sec <= r_fld.ok ? mac[EPOCH_W-1:0] : '0;
        end
    end

    assign o_busy    = (r_state != ST_IDLE);
    assign o_valid   = r_out_valid;
    assign o_ok      = r_out_ok;
    assign o_seconds = r_out_sec;

endmodule

// ----- rtl/utce_checker.sv -----
// ---------------------------------------------------------------------------
// utce_checker: port-level checks for the UTCTime converter
// Watches the stream ports of the top level; bound in below.
// ---------------------------------------------------------------------------
module utce_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // output register empties on reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid after reset");

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result word changed");

    // a rejected string carries zero seconds
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 40'd0)
        else $error("invalid result with nonzero seconds");

    // the final character starts the conversion and blocks input
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still ready after final character");

    // a new result appears only at the end of a conversion
    a_result_after_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result word without a conversion");

endmodule

bind utctime_to_epoch_seconds_top utce_checker u_utce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- verif/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench: UTCTime string to epoch seconds converter
// Streams UTCTime character strings into the converter, predicts the
// valid flag and the seconds count of every string, and compares each
// result word with the oldest prediction. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module testbench
    import utce_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          QUIET_LIMIT  = 4000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          HOLD_AFTER   = 25;
    localparam int          TAIL_CYCLES  = 20;
    localparam int          TARGET_CHARS = 850;
    localparam logic [7:0]  CH_ZERO      = 8'h30;
    localparam logic [7:0]  CH_NINE      = 8'h39;
    localparam longint      DAYS_BEFORE [12] = '{0, 31, 59, 90, 120, 151,
                                                 181, 212, 243, 273, 304, 334};

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char_word;

    typedef struct {
        logic               ok;
        logic [EPOCH_W-1:0] secs;
    } t_epoch_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] char_code
    logic        s_axis_tlast = 1'b0;  // last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // [32:0] epoch_seconds, [39:33] zero
    logic [0:0]  m_axis_tuser;         // [0] valid_res

    utctime_to_epoch_seconds_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: one parse of a UTCTime string in flight
    logic [POS_W-1:0] char_pos   = '0;
    logic [DIG_W-1:0] year_acc   = '0;
    logic [DIG_W-1:0] month_acc  = '0;
    logic [DIG_W-1:0] day_acc    = '0;
    logic [DIG_W-1:0] hour_acc   = '0;
    logic [DIG_W-1:0] minute_acc = '0;
    logic [DIG_W-1:0] second_acc = '0;
    logic [1:0]       sec_digits = SEC_NONE;
    logic             saw_bad    = 1'b0;

    t_char_word    char_queue [$];
    t_epoch_result epoch_expected [$];
    logic [7:0]    spell [$];

    int mismatches     = 0;
    int chars_pushed   = 0;
    int chars_accepted = 0;
    int results_seen   = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int quiet_cycles   = 0;
    t_char_word next_word;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [DIG_W-1:0] next_acc(input logic [DIG_W-1:0] acc,
                                                 input logic [POS_W-1:0] at,
                                                 input logic [3:0] dv);
        if (!at[0]) begin
            return DIG_W'(dv * 10);
        end
        return DIG_W'(acc + dv);
    endfunction

    function automatic longint leaps_upto(input longint y);
        return y / 4 - y / 100 + y / 400;
    endfunction

    // Advance the parse by one character; on last, push the predicted result
    task automatic take_char(input logic [CHAR_W-1:0] c, input logic lst);
        logic [POS_W-1:0] at;
        logic             digit;
        logic [3:0]       dv;
        logic             ok;
        longint           yr;
        longint           days;
        longint           total;
        t_epoch_result    res;
        at    = char_pos;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        dv    = digit ? 4'(c - CH_ZERO) : 4'd0;
        if (at < POS_SEC_HI) begin
            if (!digit) saw_bad = 1'b1;
            case (at[3:1])
                3'd0:    year_acc   = next_acc(year_acc, at, dv);
                3'd1:    month_acc  = next_acc(month_acc, at, dv);
                3'd2:    day_acc    = next_acc(day_acc, at, dv);
                3'd3:    hour_acc   = next_acc(hour_acc, at, dv);
                default: minute_acc = next_acc(minute_acc, at, dv);
            endcase
        end else if (at == POS_SEC_HI) begin
            if (digit) begin
                sec_digits = SEC_ONE;
                second_acc = next_acc(second_acc, at, dv);
            end
        end else if (at == POS_SEC_LO) begin
            if (digit && sec_digits == SEC_ONE) begin
                sec_digits = SEC_BOTH;
                second_acc = next_acc(second_acc, at, dv);
            end
        end
        if (char_pos < POS_MAX) char_pos = char_pos + 1'b1;
        if (!lst) return;

        ok = (at >= POS_MIN_LEN) && !saw_bad && (month_acc >= 1) && (month_acc <= MONTH_MAX);
        total = 0;
        if (ok) begin
            yr = 1900 + longint'(year_acc) + ((year_acc < YEAR_PIVOT) ? 100 : 0);
            days = 365 * (yr - 1970) + leaps_upto(yr - 1) - leaps_upto(1969);
            days += DAYS_BEFORE[month_acc - 1];
            if (month_acc > 2 && ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0)) days += 1;
            days += longint'(day_acc) - 1;
            total = days * 86400 + longint'(hour_acc) * 3600 + longint'(minute_acc) * 60
                  + ((sec_digits == SEC_BOTH) ? longint'(second_acc) : 0);
        end
        res.ok   = ok;
        res.secs = total[EPOCH_W-1:0];
        epoch_expected.push_back(res);

        char_pos   = '0;
        year_acc   = '0;
        month_acc  = '0;
        day_acc    = '0;
        hour_acc   = '0;
        minute_acc = '0;
        second_acc = '0;
        sec_digits = SEC_NONE;
        saw_bad    = 1'b0;
    endtask

    function automatic int pick_idle(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        while (v >= CH_ZERO && v <= CH_NINE) v = 8'($urandom_range(0, 255));
        return v;
    endfunction

    function automatic logic [7:0] any_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Mostly in range, sometimes any two-digit value
    function automatic int pick_field(input int lo, input int hi);
        if ($urandom_range(0, 9) < 8) return $urandom_range(lo, hi);
        return $urandom_range(0, 99);
    endfunction

    task automatic add_two(input int v);
        spell.push_back(CH_ZERO + 8'(v / 10));
        spell.push_back(CH_ZERO + 8'(v % 10));
    endtask

    task automatic add_text(input string s);
        foreach (s[i]) spell.push_back(s[i]);
    endtask

    // Move the spelled string to the send queue, last mark on its final char
    task automatic send_spelled();
        t_char_word w;
        foreach (spell[i]) begin
            w.code = spell[i];
            w.last = (i == spell.size() - 1);
            char_queue.push_back(w);
            chars_pushed++;
        end
        spell.delete();
    endtask

    task automatic wait_drained();
        while (chars_accepted != chars_pushed || epoch_expected.size() != 0) @(posedge i_clk);
    endtask

    // Driver: present one character word at a time, with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                take_char(s_axis_tdata, s_axis_tlast);
                chars_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (char_queue.size() > 0) begin
                    next_word = char_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_word.code;
                    s_axis_tlast  <= next_word.last;
                    gap_left      <= pick_idle(((chars_accepted / 64) % 4) == 0);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: one long hold-off, otherwise random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left    <= pick_idle(((results_seen / 12) % 3) == 0);
        end
    end

    // Monitor: compare every result word with the oldest prediction
    always @(posedge i_clk) begin
        t_epoch_result e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (epoch_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected result tuser=%0b tdata=%h",
                                          m_axis_tuser, m_axis_tdata));
            end else begin
                e = epoch_expected.pop_front();
                if (m_axis_tuser[0] !== e.ok)
                    report_mismatch($sformatf("result %0d valid_res got %b want %b",
                                              results_seen, m_axis_tuser[0], e.ok));
                if (m_axis_tdata[EPOCH_W-1:0] !== e.secs)
                    report_mismatch($sformatf("result %0d epoch_seconds got %h want %h",
                                              results_seen, m_axis_tdata[EPOCH_W-1:0], e.secs));
                if (m_axis_tdata[39:EPOCH_W] !== '0)
                    report_mismatch($sformatf("result %0d pad bits got %h",
                                              results_seen, m_axis_tdata[39:EPOCH_W]));
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int r;
        int k;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Epoch itself plus two seconds digits
        add_text("700101000059");
        send_spelled();
        // Last 20xx year, day zero, hour and minute past range
        add_text("4912009999");
        send_spelled();
        // Lowest and highest byte in a too-short string
        spell.push_back(8'hFF);
        spell.push_back(8'h00);
        send_spelled();
        wait_drained();

        while (chars_pushed < TARGET_CHARS) begin
            r = $urandom_range(0, 99);
            if (r < 68) begin
                add_two($urandom_range(0, 99));
                add_two(pick_field(1, 12));
                add_two(pick_field(1, 31));
                add_two(pick_field(0, 23));
                add_two(pick_field(0, 59));
                k = $urandom_range(0, 9);
                if (k < 6) begin
                    add_two(pick_field(0, 59));
                end else if (k < 8) begin
                    // one seconds digit only, then maybe a non-digit
                    spell.push_back(any_digit());
                    if ($urandom_range(0, 1)) spell.push_back(non_digit());
                end else if (k == 8) begin
                    spell.push_back(non_digit());
                    spell.push_back(any_digit());
                end
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 6)) spell.push_back(8'($urandom_range(0, 255)));
                end
            end else if (r < 80) begin
                repeat ($urandom_range(1, 9)) spell.push_back(any_digit());
            end else if (r < 90) begin
                repeat ($urandom_range(10, 12)) spell.push_back(any_digit());
                spell[$urandom_range(0, 9)] = non_digit();
            end else begin
                repeat ($urandom_range(1, 20)) spell.push_back(8'($urandom_range(0, 255)));
            end
            send_spelled();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (epoch_expected.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", epoch_expected.size()));
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
